// ===== sv/sip_pkg.sv =====
// ----------------------------------------------------------------------------
// sip_pkg: shared types and constants
// Widths for the segment/plane intersection pipeline and its divider stages.
// ----------------------------------------------------------------------------
package sip_pkg;

    localparam int CW = 32;          // coordinate width
    localparam int FB = 16;          // fraction bits
    localparam int DW = CW + 1;      // difference width
    localparam int PW = DW + CW;     // product width
    localparam int SW = PW + 2;      // three-term sum width
    localparam int RW = SW + 1;      // remainder width, holds 2*r
    localparam int QW = FB + 1;      // quotient width, 0..2^FB

    typedef struct packed {
        logic                 hit;
        logic signed [DW-1:0] dir_x;
        logic signed [DW-1:0] dir_y;
        logic signed [DW-1:0] dir_z;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] start_z;
    } carry_t;

    typedef struct packed {
        logic          valid;
        logic [RW-1:0] rem;
        logic [SW-1:0] den;
        logic [QW-1:0] quo;
        carry_t        carry;
    } div_t;

endpackage

// ===== sv/sip_div.sv =====
// ----------------------------------------------------------------------------
// sip_div: pipelined restoring divider
// One quotient bit per stage; the first stage takes the integer bit.
// ----------------------------------------------------------------------------
module sip_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  sip_pkg::div_t   div_in,
    output sip_pkg::div_t   div_out
);

    sip_pkg::div_t stage_reg [sip_pkg::QW+1];
    sip_pkg::div_t stage_next [sip_pkg::QW];

    assign stage_reg[0] = div_in;
    assign div_out      = stage_reg[sip_pkg::QW];

    for (genvar k = 0; k < sip_pkg::QW; k++) begin : g_step
        logic [sip_pkg::RW-1:0] trial;

        always_comb begin
            stage_next[k] = stage_reg[k];
            trial = (k == 0) ? stage_reg[k].rem
                             : {stage_reg[k].rem[sip_pkg::RW-2:0], 1'b0};
            if (trial >= {1'b0, stage_reg[k].den}) begin
                stage_next[k].rem = trial - {1'b0, stage_reg[k].den};
                stage_next[k].quo = {stage_reg[k].quo[sip_pkg::QW-2:0], 1'b1};
            end else begin
                stage_next[k].rem = trial;
                stage_next[k].quo = {stage_reg[k].quo[sip_pkg::QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stage_reg[k+1].valid <= 1'b0;
            end else if (ce) begin
                stage_reg[k+1].valid <= stage_next[k].valid;
            end
            if (ce) begin
                stage_reg[k+1].rem   <= stage_next[k].rem;
                stage_reg[k+1].den   <= stage_next[k].den;
                stage_reg[k+1].quo   <= stage_next[k].quo;
                stage_reg[k+1].carry <= stage_next[k].carry;
            end
        end
    end

endmodule

// ===== sv/segment_plane_intersection.sv =====
// ----------------------------------------------------------------------------
// segment_plane_intersection: segment versus plane hit test
// Fixed-point Q16.16 pipeline: dot products, parameter t, hit point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one word per test, a plane point, plane normal and
//   segment start/end, all signed Q16.16. Output channel m_*: one word per
//   input word, in order: m_hit and the crossing point (zero on no hit).
//   From acceptance to m_valid a word passes differences, products,
//   sums, sign fix and range check, 17 divider stages (one quotient bit
//   each), scale multiply and final add.
//   Throughput is one word per cycle; all stages advance together.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds, bubbles included, and s_ready drops. Nothing is lost or
//   repeated.
//   Reset (aresetn low, synchronous) clears every stage valid bit; data
//   registers are not reset.
// ----------------------------------------------------------------------------
module segment_plane_intersection (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [sip_pkg::CW-1:0] s_plane_x,
    input  logic signed [sip_pkg::CW-1:0] s_plane_y,
    input  logic signed [sip_pkg::CW-1:0] s_plane_z,
    input  logic signed [sip_pkg::CW-1:0] s_normal_x,
    input  logic signed [sip_pkg::CW-1:0] s_normal_y,
    input  logic signed [sip_pkg::CW-1:0] s_normal_z,
    input  logic signed [sip_pkg::CW-1:0] s_start_x,
    input  logic signed [sip_pkg::CW-1:0] s_start_y,
    input  logic signed [sip_pkg::CW-1:0] s_start_z,
    input  logic signed [sip_pkg::CW-1:0] s_end_x,
    input  logic signed [sip_pkg::CW-1:0] s_end_y,
    input  logic signed [sip_pkg::CW-1:0] s_end_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic signed [sip_pkg::CW-1:0] m_cross_x,
    output logic signed [sip_pkg::CW-1:0] m_cross_y,
    output logic signed [sip_pkg::CW-1:0] m_cross_z
);

    localparam int CW = sip_pkg::CW;
    localparam int DW = sip_pkg::DW;
    localparam int PW = sip_pkg::PW;
    localparam int SW = sip_pkg::SW;
    localparam int QW = sip_pkg::QW;
    localparam int FB = sip_pkg::FB;
    localparam int MW = QW + 1 + DW;   // scale product width

    // global advance: move unless a result is stuck at the output
    logic ce;
    assign ce      = m_ready | ~m_valid;
    assign s_ready = ce;

    // ---- stage 1: differences ----
    logic                 v1_reg;
    logic signed [DW-1:0] dir_reg [3];
    logic signed [DW-1:0] off_reg [3];
    logic signed [CW-1:0] nrm_reg [3];
    logic signed [CW-1:0] st1_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_valid;
        end
        if (ce) begin
            dir_reg[0] <= DW'(s_end_x) - DW'(s_start_x);
            dir_reg[1] <= DW'(s_end_y) - DW'(s_start_y);
            dir_reg[2] <= DW'(s_end_z) - DW'(s_start_z);
            off_reg[0] <= DW'(s_plane_x) - DW'(s_start_x);
            off_reg[1] <= DW'(s_plane_y) - DW'(s_start_y);
            off_reg[2] <= DW'(s_plane_z) - DW'(s_start_z);
            nrm_reg[0] <= s_normal_x;
            nrm_reg[1] <= s_normal_y;
            nrm_reg[2] <= s_normal_z;
            st1_reg[0] <= s_start_x;
            st1_reg[1] <= s_start_y;
            st1_reg[2] <= s_start_z;
        end
    end

    // ---- stage 2: six products ----
    logic                 v2_reg;
    logic signed [PW-1:0] pd_reg [3];
    logic signed [PW-1:0] pn_reg [3];
    logic signed [DW-1:0] dir2_reg [3];
    logic signed [CW-1:0] st2_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= v1_reg;
        end
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                pd_reg[i]   <= PW'(nrm_reg[i]) * PW'(dir_reg[i]);
                pn_reg[i]   <= PW'(nrm_reg[i]) * PW'(off_reg[i]);
                dir2_reg[i] <= dir_reg[i];
                st2_reg[i]  <= st1_reg[i];
            end
        end
    end

    // ---- stage 3: dot product sums ----
    logic                 v3_reg;
    logic signed [SW-1:0] den3_reg;
    logic signed [SW-1:0] num3_reg;
    logic signed [DW-1:0] dir3_reg [3];
    logic signed [CW-1:0] st3_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (ce) begin
            v3_reg <= v2_reg;
        end
        if (ce) begin
            den3_reg <= SW'(pd_reg[0]) + SW'(pd_reg[1]) + SW'(pd_reg[2]);
            num3_reg <= SW'(pn_reg[0]) + SW'(pn_reg[1]) + SW'(pn_reg[2]);
            dir3_reg <= dir2_reg;
            st3_reg  <= st2_reg;
        end
    end

    // ---- stage 4: sign fix and range check, feeds divider ----
    logic [SW-1:0]   den_abs;
    logic [SW-1:0]   num_fix;
    logic            hit_now;
    sip_pkg::div_t   div_next;
    sip_pkg::div_t   div_in_reg;
    sip_pkg::div_t   div_out;

    always_comb begin
        den_abs = den3_reg[SW-1] ? SW'(-den3_reg) : den3_reg;
        num_fix = den3_reg[SW-1] ? SW'(-num3_reg) : num3_reg;
        hit_now = (den_abs != '0) && !num_fix[SW-1] && (num_fix <= den_abs);
        div_next.valid         = v3_reg;
        div_next.rem           = {1'b0, num_fix};
        div_next.den           = den_abs;
        div_next.quo           = '0;
        div_next.carry.hit     = hit_now;
        div_next.carry.dir_x   = dir3_reg[0];
        div_next.carry.dir_y   = dir3_reg[1];
        div_next.carry.dir_z   = dir3_reg[2];
        div_next.carry.start_x = st3_reg[0];
        div_next.carry.start_y = st3_reg[1];
        div_next.carry.start_z = st3_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_in_reg.valid <= 1'b0;
        end else if (ce) begin
            div_in_reg.valid <= div_next.valid;
        end
        if (ce) begin
            div_in_reg.rem   <= div_next.rem;
            div_in_reg.den   <= div_next.den;
            div_in_reg.quo   <= div_next.quo;
            div_in_reg.carry <= div_next.carry;
        end
    end

    sip_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .div_in  (div_in_reg),
        .div_out (div_out)
    );

    // ---- scale: t * dir ----
    logic                 vm_reg;
    logic                 hm_reg;
    logic signed [MW-1:0] sc_reg [3];
    logic signed [CW-1:0] stm_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
        end else if (ce) begin
            vm_reg <= div_out.valid;
        end
        if (ce) begin
            hm_reg     <= div_out.carry.hit;
            sc_reg[0]  <= MW'($signed({1'b0, div_out.quo})) * MW'(div_out.carry.dir_x);
            sc_reg[1]  <= MW'($signed({1'b0, div_out.quo})) * MW'(div_out.carry.dir_y);
            sc_reg[2]  <= MW'($signed({1'b0, div_out.quo})) * MW'(div_out.carry.dir_z);
            stm_reg[0] <= div_out.carry.start_x;
            stm_reg[1] <= div_out.carry.start_y;
            stm_reg[2] <= div_out.carry.start_z;
        end
    end

    // ---- output register: start + (t*dir >>> FB) ----
    logic                 vo_reg;
    logic                 ho_reg;
    logic signed [CW-1:0] xo_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (ce) begin
            vo_reg <= vm_reg;
        end
        if (ce) begin
            ho_reg <= hm_reg;
            for (int i = 0; i < 3; i++) begin
                xo_reg[i] <= hm_reg ? (stm_reg[i] + sc_reg[i][FB+CW-1:FB]) : '0;
            end
        end
    end

    assign m_valid   = vo_reg;
    assign m_hit     = ho_reg;
    assign m_cross_x = xo_reg[0];
    assign m_cross_y = xo_reg[1];
    assign m_cross_z = xo_reg[2];

endmodule
